// File: rtl/midell_pkg.sv
`default_nettype none

package midell_pkg;

  // default field widths
  localparam int MIDELL_RADIUS_W = 10;
  localparam int MIDELL_COORD_W  = 12;

  // command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // sequencer states
  typedef enum logic [14:0] {
    ST_IDLE = 15'b000000000000001,
    ST_RX2  = 15'b000000000000010,
    ST_RY2  = 15'b000000000000100,
    ST_KA   = 15'b000000000001000,
    ST_KB   = 15'b000000000010000,
    ST_KC   = 15'b000000000100000,
    ST_P2   = 15'b000000001000000,
    ST_TST  = 15'b000000010000000,
    ST_B2   = 15'b000000100000000,
    ST_M1   = 15'b000001000000000,
    ST_M2   = 15'b000010000000000,
    ST_DV   = 15'b000100000000000,
    ST_DV2  = 15'b001000000000000,
    ST_UPD  = 15'b010000000000000,
    ST_ACC  = 15'b100000000000000
  } midell_state_t;

endpackage

`default_nettype wire

// File: rtl/midell_mul.sv
`default_nettype none

module midell_mul #(
  parameter int A_WIDTH = 25,
  parameter int B_WIDTH = 21
) (
  input  wire logic                               clk,
  input  wire logic signed [A_WIDTH-1:0]          mul_a,
  input  wire logic signed [B_WIDTH-1:0]          mul_b,
  output      logic signed [A_WIDTH+B_WIDTH-1:0]  prod_r
);

  // one signed product per cycle, registered
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

endmodule

`default_nettype wire

// File: rtl/midell_ctrl.sv
`default_nettype none

module midell_ctrl import midell_pkg::*; #(
  parameter int RADIUS_WIDTH = MIDELL_RADIUS_W,
  parameter int COORD_WIDTH  = MIDELL_COORD_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          in_command,
  input  wire logic [RADIUS_WIDTH-1:0]       in_center_x,
  input  wire logic [RADIUS_WIDTH-1:0]       in_center_y,
  input  wire logic [RADIUS_WIDTH-1:0]       in_radius_x,
  input  wire logic [RADIUS_WIDTH-1:0]       in_radius_y,
  input  wire logic                          out_free,
  output      logic                          emit,
  output      logic signed [COORD_WIDTH-1:0] pt_right_x,
  output      logic signed [COORD_WIDTH-1:0] pt_left_x,
  output      logic signed [COORD_WIDTH-1:0] pt_upper_y,
  output      logic signed [COORD_WIDTH-1:0] pt_lower_y,
  output      logic                          pt_last
);

  localparam int RW  = RADIUS_WIDTH;
  localparam int CW  = COORD_WIDTH;
  localparam int XW  = RW + 1;
  localparam int YW  = RW + 2;
  localparam int SQW = 2 * RW;
  localparam int MA  = 2 * RW + 5;
  localparam int MB  = 2 * RW + 1;
  localparam int PW  = MA + MB;
  localparam int DW  = 4 * RW + 8;
  localparam int SW  = (CW > RW + 3) ? CW : RW + 3;

  midell_state_t state_r, state_nxt;

  logic                 busy_r, busy_nxt;
  logic                 region2_r, region2_nxt;
  logic [XW-1:0]        x_r, x_nxt;
  logic signed [YW-1:0] y_r, y_nxt;
  logic signed [DW-1:0] dec_r, dec_nxt;
  logic [RW-1:0]        cx_r, cx_nxt;
  logic [RW-1:0]        cy_r, cy_nxt;
  logic [RW-1:0]        rx_r, rx_nxt;
  logic [RW-1:0]        ry_r, ry_nxt;
  logic [SQW-1:0]       rx2_r, rx2_nxt;
  logic [SQW-1:0]       ry2_r, ry2_nxt;
  logic [2*SQW-1:0]     k_r, k_nxt;
  logic signed [PW-1:0] p1_r, p1_nxt;
  logic signed [DW-1:0] u_r, u_nxt;
  logic signed [DW-1:0] v_r, v_nxt;
  logic [MA-1:0]        t1_r, t1_nxt;
  logic signed [DW-1:0] acc_r, acc_nxt;
  logic signed [DW-1:0] delta_r, delta_nxt;

  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PW-1:0] prod_r;

  logic signed [DW-1:0] prod_w, p1_w, rx2_w, ry2_w, k_w;
  logic signed [YW:0]   ym1;
  logic signed [SW-1:0] cx_e, cy_e, x_e, y_e;
  logic                 in_accept;
  logic                 to_region2;
  logic                 dec_neg, dec_pos;
  logic                 round_up;
  logic                 use_u, use_v;

  midell_mul #(
    .A_WIDTH (MA),
    .B_WIDTH (MB)
  ) u_mul (
    .clk    (clk),
    .mul_a  (mul_a),
    .mul_b  (mul_b),
    .prod_r (prod_r)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;

  assign prod_w = {{(DW-PW){prod_r[PW-1]}}, prod_r};
  assign p1_w   = {{(DW-PW){p1_r[PW-1]}}, p1_r};
  assign rx2_w  = $signed({{(DW-SQW){1'b0}}, rx2_r});
  assign ry2_w  = $signed({{(DW-SQW){1'b0}}, ry2_r});
  assign k_w    = $signed({{(DW-2*SQW){1'b0}}, k_r});

  assign ym1 = $signed({y_r[YW-1], y_r}) - $signed((YW+1)'(1));

  assign to_region2 = !region2_r && !(p1_r < prod_r);
  assign dec_neg    = dec_r[DW-1];
  assign dec_pos    = !dec_r[DW-1] && (dec_r != '0);
  assign round_up   = acc_r[DW-1] && (acc_r[1:0] != 2'b00);

  // point set from the offsets before this step
  assign cx_e = $signed({{(SW-RW){1'b0}}, cx_r});
  assign cy_e = $signed({{(SW-RW){1'b0}}, cy_r});
  assign x_e  = $signed({{(SW-XW){1'b0}}, x_r});
  assign y_e  = {{(SW-YW){y_r[YW-1]}}, y_r};

  always_comb begin
    logic signed [SW-1:0] s_rx, s_lx, s_uy, s_ly;
    s_rx = cx_e + x_e;
    s_lx = cx_e - x_e;
    s_uy = cy_e - y_e;
    s_ly = cy_e + y_e;
    pt_right_x = s_rx[CW-1:0];
    pt_left_x  = s_lx[CW-1:0];
    pt_upper_y = s_uy[CW-1:0];
    pt_lower_y = s_ly[CW-1:0];
  end

  assign pt_last = region2_r && ym1[YW];

  // shared multiplier operand select
  always_comb begin
    mul_a = $signed({{(MA-XW){1'b0}}, x_r});
    mul_b = $signed({1'b0, ry2_r});
    case (state_r)
      ST_RX2: begin
        mul_a = $signed({{(MA-RW){1'b0}}, rx_r});
        mul_b = $signed({{(MB-RW){1'b0}}, rx_r});
      end
      ST_RY2: begin
        mul_a = $signed({{(MA-RW){1'b0}}, ry_r});
        mul_b = $signed({{(MB-RW){1'b0}}, ry_r});
      end
      ST_KA: begin
        mul_a = $signed({{(MA-SQW){1'b0}}, rx2_r});
        mul_b = $signed({{(MB-RW){1'b0}}, ry_r});
      end
      ST_KB: begin
        mul_a = $signed({{(MA-SQW){1'b0}}, rx2_r});
        mul_b = $signed({1'b0, ry2_r});
      end
      ST_P2: begin
        mul_a = {{(MA-YW){y_r[YW-1]}}, y_r};
        mul_b = $signed({1'b0, rx2_r});
      end
      ST_TST: begin
        mul_a = $signed({{(MA-XW-1){1'b0}}, x_r, 1'b1});
        mul_b = $signed({{(MB-XW-1){1'b0}}, x_r, 1'b1});
      end
      ST_B2: begin
        mul_a = {{(MA-YW-1){ym1[YW]}}, ym1};
        mul_b = {{(MB-YW-1){ym1[YW]}}, ym1};
      end
      ST_M1: begin
        mul_a = $signed(t1_r);
        mul_b = $signed({1'b0, ry2_r});
      end
      ST_M2: begin
        mul_a = $signed(t1_r);
        mul_b = $signed({1'b0, rx2_r});
      end
      default: begin
        mul_a = $signed({{(MA-XW){1'b0}}, x_r});
        mul_b = $signed({1'b0, ry2_r});
      end
    endcase
  end

  // sequencer and datapath
  always_comb begin
    state_nxt   = state_r;
    busy_nxt    = busy_r;
    region2_nxt = region2_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    dec_nxt     = dec_r;
    cx_nxt      = cx_r;
    cy_nxt      = cy_r;
    rx_nxt      = rx_r;
    ry_nxt      = ry_r;
    rx2_nxt     = rx2_r;
    ry2_nxt     = ry2_r;
    k_nxt       = k_r;
    p1_nxt      = p1_r;
    u_nxt       = u_r;
    v_nxt       = v_r;
    t1_nxt      = t1_r;
    acc_nxt     = acc_r;
    delta_nxt   = delta_r;
    emit        = 1'b0;
    use_u       = 1'b0;
    use_v       = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_command == CMD_START) begin
            cx_nxt      = in_center_x;
            cy_nxt      = in_center_y;
            rx_nxt      = in_radius_x;
            ry_nxt      = in_radius_y;
            x_nxt       = '0;
            y_nxt       = $signed({2'b00, in_radius_y});
            region2_nxt = 1'b0;
            busy_nxt    = 1'b1;
            state_nxt   = ST_RX2;
          end else if (in_command == CMD_STEP && busy_r) begin
            // x * ry^2 is already on its way out of the multiplier
            state_nxt = ST_P2;
          end
        end
      end
      ST_RX2: state_nxt = ST_RY2;
      ST_RY2: begin
        rx2_nxt   = prod_r[SQW-1:0];
        state_nxt = ST_KA;
      end
      ST_KA: begin
        ry2_nxt   = prod_r[SQW-1:0];
        state_nxt = ST_KB;
      end
      ST_KB: begin
        // region-1 start value
        dec_nxt   = ry2_w - prod_w + $signed({{(DW-SQW+2){1'b0}}, rx2_r[SQW-1:2]});
        state_nxt = ST_KC;
      end
      ST_KC: begin
        k_nxt     = prod_r[2*SQW-1:0];
        state_nxt = ST_IDLE;
      end
      ST_P2: begin
        p1_nxt    = prod_r;
        state_nxt = ST_TST;
      end
      ST_TST: begin
        // slope test, and the doubled products of the new offsets
        u_nxt     = (p1_w + ry2_w) <<< 1;
        v_nxt     = (prod_w - rx2_w) <<< 1;
        state_nxt = to_region2 ? ST_B2 : ST_UPD;
      end
      ST_B2: begin
        t1_nxt    = prod_r[MA-1:0];
        state_nxt = ST_M1;
      end
      ST_M1: begin
        t1_nxt    = prod_r[MA-1:0];
        state_nxt = ST_M2;
      end
      ST_M2: begin
        acc_nxt   = prod_w - (k_w <<< 2);
        state_nxt = ST_DV;
      end
      ST_DV: begin
        acc_nxt   = acc_r + (prod_w <<< 2);
        state_nxt = ST_DV2;
      end
      ST_DV2: begin
        // divide by four, truncating toward zero
        dec_nxt     = (acc_r >>> 2) + $signed({{(DW-1){1'b0}}, round_up});
        region2_nxt = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          emit = 1'b1;
          if (!region2_r) begin
            use_u = 1'b1;
            use_v = !dec_neg;
            x_nxt = x_r + XW'(1);
            if (!dec_neg) begin
              y_nxt = ym1[YW-1:0];
            end
          end else begin
            use_u = !dec_pos;
            use_v = 1'b1;
            y_nxt = ym1[YW-1:0];
            if (!dec_pos) begin
              x_nxt = x_r + XW'(1);
            end
            if (ym1[YW]) begin
              busy_nxt = 1'b0;
            end
          end
          delta_nxt = (use_u ? u_r : '0) - (use_v ? v_r : '0)
                      + (region2_r ? rx2_w : ry2_w);
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        dec_nxt   = dec_r + delta_r;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      busy_r    <= 1'b0;
      region2_r <= 1'b0;
      x_r       <= '0;
      y_r       <= '0;
      dec_r     <= '0;
      cx_r      <= '0;
      cy_r      <= '0;
      rx_r      <= '0;
      ry_r      <= '0;
      rx2_r     <= '0;
      ry2_r     <= '0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      busy_r    <= busy_nxt;
      region2_r <= region2_nxt;
      x_r       <= x_nxt;
      y_r       <= y_nxt;
      dec_r     <= dec_nxt;
      cx_r      <= cx_nxt;
      cy_r      <= cy_nxt;
      rx_r      <= rx_nxt;
      ry_r      <= ry_nxt;
      rx2_r     <= rx2_nxt;
      ry2_r     <= ry2_nxt;
      k_r       <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p1_r    <= p1_nxt;
    u_r     <= u_nxt;
    v_r     <= v_nxt;
    t1_r    <= t1_nxt;
    acc_r   <= acc_nxt;
    delta_r <= delta_nxt;
  end

`ifndef SYNTHESIS
  a_emit_then_acc: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (state_r == ST_ACC))
    else $error("point set emitted without moving to the accumulate step");

  a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && pt_last) |=> !busy_r)
    else $error("final point set did not end the ellipse");

  a_region2_only_cleared_on_start: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(region2_r) |-> $past(in_accept && (in_command == CMD_START)))
    else $error("region two left without a start word");

  a_region2_entry_path: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(region2_r) |-> ($past(state_r) == ST_DV2))
    else $error("region two entered outside the switch sequence");
`endif

endmodule

`default_nettype wire

// File: rtl/midpoint_ellipse_rasterizer_unit.sv
// start word: input stalled through the multiplier steps RX2, RY2, KA, KB and KC; no result
// step word: P2, TST, UPD (holds until the output register is free, then emits), ACC
// step word that crosses into region 2: B2, M1, M2, DV and DV2 come between TST and UPD
// all products go through one shared registered multiplier; next word taken back in IDLE
// synchronous active-low reset clears the sequencer, run state and output valid
`default_nettype none

module midpoint_ellipse_rasterizer_unit import midell_pkg::*; #(
  parameter int RADIUS_WIDTH = MIDELL_RADIUS_W,
  parameter int COORD_WIDTH  = MIDELL_COORD_W
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // command words
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          in_command,
  input  wire logic [RADIUS_WIDTH-1:0]       in_center_x,
  input  wire logic [RADIUS_WIDTH-1:0]       in_center_y,
  input  wire logic [RADIUS_WIDTH-1:0]       in_radius_x,
  input  wire logic [RADIUS_WIDTH-1:0]       in_radius_y,
  // point-set words
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic signed [COORD_WIDTH-1:0] out_right_x,
  output      logic signed [COORD_WIDTH-1:0] out_left_x,
  output      logic signed [COORD_WIDTH-1:0] out_upper_y,
  output      logic signed [COORD_WIDTH-1:0] out_lower_y,
  output      logic                          out_last
);

  logic                          out_valid_r, out_valid_nxt;
  logic signed [COORD_WIDTH-1:0] right_x_r, left_x_r, upper_y_r, lower_y_r;
  logic                          last_r;

  logic                          out_free;
  logic                          emit;
  logic signed [COORD_WIDTH-1:0] pt_right_x, pt_left_x, pt_upper_y, pt_lower_y;
  logic                          pt_last;

  // the output register frees up in the same cycle its word is taken
  assign out_free = !out_valid_r || !out_stall;

  // sequencer, datapath and the shared multiplier
  midell_ctrl #(
    .RADIUS_WIDTH (RADIUS_WIDTH),
    .COORD_WIDTH  (COORD_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius_x (in_radius_x),
    .in_radius_y (in_radius_y),
    .out_free    (out_free),
    .emit        (emit),
    .pt_right_x  (pt_right_x),
    .pt_left_x   (pt_left_x),
    .pt_upper_y  (pt_upper_y),
    .pt_lower_y  (pt_lower_y),
    .pt_last     (pt_last)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload held while the word waits
  always_ff @(posedge clk) begin
    if (emit) begin
      right_x_r <= pt_right_x;
      left_x_r  <= pt_left_x;
      upper_y_r <= pt_upper_y;
      lower_y_r <= pt_lower_y;
      last_r    <= pt_last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_right_x = right_x_r;
  assign out_left_x  = left_x_r;
  assign out_upper_y = upper_y_r;
  assign out_lower_y = lower_y_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire

// File: tb/midpoint_ellipse_rasterizer_unit_test.sv
`default_nettype none

module midpoint_ellipse_rasterizer_unit_test;
  import midell_pkg::*;

  localparam int RW = MIDELL_RADIUS_W;
  localparam int CW = MIDELL_COORD_W;

  // one point set as the block should present it
  typedef struct packed {
    logic signed [CW-1:0] right_x;
    logic signed [CW-1:0] left_x;
    logic signed [CW-1:0] upper_y;
    logic signed [CW-1:0] lower_y;
    logic                 last;
  } point_set_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // command side, all known from time zero
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic          in_command = CMD_STEP;
  logic [RW-1:0] in_center_x = '0;
  logic [RW-1:0] in_center_y = '0;
  logic [RW-1:0] in_radius_x = '0;
  logic [RW-1:0] in_radius_y = '0;

  // point-set side
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic signed [CW-1:0] out_right_x;
  logic signed [CW-1:0] out_left_x;
  logic signed [CW-1:0] out_upper_y;
  logic signed [CW-1:0] out_lower_y;
  logic                 out_last;

  // idling percentages, changed only at a falling edge
  int send_idle_pct = 0;
  int stall_pct = 0;

  // long receiver hold-off, asked for by the pressure test
  int hold_length = 0;
  int hold_left = 0;

  int mismatches = 0;

  // point sets predicted but not yet seen, oldest first
  point_set_t pending_point_sets[$];

  // the tracer's own copy of the ellipse walk
  bit     ellipse_active = 1'b0;
  bit     lower_arc = 1'b0;
  longint walk_x = 0;
  longint walk_y = 0;
  longint decision = 0;
  longint ctr_x = 0;
  longint ctr_y = 0;
  longint rad_x = 0;
  longint rad_y = 0;

  midpoint_ellipse_rasterizer_unit u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_command),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius_x (in_radius_x),
    .in_radius_y (in_radius_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_right_x (out_right_x),
    .out_left_x  (out_left_x),
    .out_upper_y (out_upper_y),
    .out_lower_y (out_lower_y),
    .out_last    (out_last)
  );

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // generous overall limit
  initial begin
    #8000000;
    $display("midpoint_ellipse_rasterizer_unit_test failed");
    $finish;
  end

  // one accepted command word through the tracer; returns 1 when it yields a point set
  function automatic bit trace_ellipse_word(input logic cmd, input logic [RW-1:0] cx,
                                            input logic [RW-1:0] cy, input logic [RW-1:0] rx,
                                            input logic [RW-1:0] ry, output point_set_t ps);
    longint rx2;
    longint ry2;
    longint a;
    longint b;
    longint sum;
    ps = '0;
    if (cmd == CMD_START) begin
      // latch and load region-1 decision, nothing emitted
      ctr_x = cx;
      ctr_y = cy;
      rad_x = rx;
      rad_y = ry;
      rx2 = rad_x * rad_x;
      ry2 = rad_y * rad_y;
      walk_x = 0;
      walk_y = rad_y;
      decision = ry2 - rx2 * rad_y + rx2 / 4;
      lower_arc = 1'b0;
      ellipse_active = 1'b1;
      return 1'b0;
    end
    // step while idle is dropped
    if (!ellipse_active) return 1'b0;
    rx2 = rad_x * rad_x;
    ry2 = rad_y * rad_y;
    // slope test fails: switch to region 2 before emitting
    if (!lower_arc && !(walk_x * ry2 < walk_y * rx2)) begin
      a = 2 * walk_x + 1;
      b = walk_y - 1;
      lower_arc = 1'b1;
      // sv division truncates toward zero
      decision = (a * a * ry2 + 4 * b * b * rx2 - 4 * rx2 * ry2) / 4;
    end
    // coordinates wrap to the output width
    sum = ctr_x + walk_x;
    ps.right_x = sum[CW-1:0];
    sum = ctr_x - walk_x;
    ps.left_x = sum[CW-1:0];
    sum = ctr_y - walk_y;
    ps.upper_y = sum[CW-1:0];
    sum = ctr_y + walk_y;
    ps.lower_y = sum[CW-1:0];
    if (!lower_arc) begin
      if (decision < 0) begin
        walk_x = walk_x + 1;
        decision = decision + 2 * ry2 * walk_x + ry2;
      end else begin
        walk_x = walk_x + 1;
        walk_y = walk_y - 1;
        decision = decision + 2 * ry2 * walk_x + ry2 - 2 * rx2 * walk_y;
      end
    end else begin
      if (decision > 0) begin
        walk_y = walk_y - 1;
        decision = decision + rx2 - 2 * rx2 * walk_y;
      end else begin
        walk_y = walk_y - 1;
        walk_x = walk_x + 1;
        decision = decision + 2 * ry2 * walk_x - 2 * rx2 * walk_y + rx2;
      end
      // y below zero ends the ellipse
      if (walk_y < 0) begin
        ps.last = 1'b1;
        ellipse_active = 1'b0;
      end
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic signed [CW-1:0] got,
                               input logic signed [CW-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // receiver side: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_length != 0) begin
      hold_left = hold_length;
      hold_length = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // point-set checker: everything is settled at the falling edge, and a word seen
  // valid and unstalled here is taken at the next rising edge
  always @(negedge clk) begin
    point_set_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_point_sets.size() == 0) begin
        report_mismatch("point set word with none expected");
      end else begin
        want = pending_point_sets.pop_front();
        compare_field("right_x", out_right_x, want.right_x);
        compare_field("left_x", out_left_x, want.left_x);
        compare_field("upper_y", out_upper_y, want.upper_y);
        compare_field("lower_y", out_lower_y, want.lower_y);
        if (out_last !== want.last)
          report_mismatch($sformatf("last got %b want %b", out_last, want.last));
      end
    end
  end

  // offer one command word, wait for it to be taken, then trace it
  task automatic send_word(input logic cmd, input logic [RW-1:0] cx, input logic [RW-1:0] cy,
                           input logic [RW-1:0] rx, input logic [RW-1:0] ry);
    bit taken;
    point_set_t ps;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_command <= cmd;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius_x <= rx;
    in_radius_y <= ry;
    // stall is stable from the falling edge to the next rising edge
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (trace_ellipse_word(cmd, cx, cy, rx, ry, ps))
      pending_point_sets.push_back(ps);
  endtask

  task automatic start_word(input logic [RW-1:0] cx, input logic [RW-1:0] cy,
                            input logic [RW-1:0] rx, input logic [RW-1:0] ry);
    send_word(CMD_START, cx, cy, rx, ry);
  endtask

  // step word: payload is ignored, so it carries noise
  task automatic step_word();
    send_word(CMD_STEP, RW'($urandom), RW'($urandom), RW'($urandom), RW'($urandom));
  endtask

  // drop valid and let everything predicted drain, then the start latency
  task automatic wait_quiet();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (pending_point_sets.size() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (12) @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(negedge clk);
    send_idle_pct = send_pct;
    stall_pct = recv_pct;
    @(posedge clk);
  endtask

  // extremes of every field, both commands, idle step, abandon, zero radii, region switch
  task automatic test_directed_extremes();
    set_idling(0, 0);
    // step before any start: no word out
    step_word();
    // both radii zero: single set, marked last
    start_word('0, '0, '0, '0);
    step_word();
    // step after the ellipse ended is dropped
    step_word();
    // top corner, widest rx, flat ry
    start_word('1, '1, '1, '0);
    step_word();
    // zero rx walks y straight down in region 2
    start_word('0, '1, '0, RW'(3));
    while (ellipse_active) step_word();
    // full-size radii, upper y goes negative; abandoned after a few steps
    start_word('1, '0, '1, '1);
    repeat (4) step_word();
    // start while busy, small ellipse run through the region switch to the end
    start_word(RW'(10'h2AA), RW'(10'h155), RW'(3), RW'(2));
    while (ellipse_active) step_word();
    wait_quiet();
  endtask

  // mostly complete ellipses with random content, some abandoned, some idle steps
  task automatic test_random_ellipses(input int n_words, input int send_pct,
                                      input int recv_pct);
    int sent;
    int pick;
    int max_steps;
    int steps;
    bit was_active;
    logic [RW-1:0] rx;
    logic [RW-1:0] ry;
    set_idling(send_pct, recv_pct);
    sent = 0;
    while (sent < n_words) begin
      pick = $urandom_range(99);
      max_steps = 1 << 20;
      if (pick < 75) begin
        rx = RW'($urandom_range(15));
        ry = RW'($urandom_range(15));
        if ($urandom_range(9) == 0) max_steps = $urandom_range(8);
      end else if (pick < 90) begin
        rx = RW'($urandom_range(60));
        ry = RW'($urandom_range(60));
      end else begin
        // full-range radii take too long to finish, so cut them short
        rx = RW'($urandom);
        ry = RW'($urandom);
        max_steps = $urandom_range(1, 30);
      end
      start_word(RW'($urandom), RW'($urandom), rx, ry);
      sent++;
      steps = 0;
      while (ellipse_active && steps < max_steps) begin
        step_word();
        steps++;
        sent++;
      end
      // stray step, dropped when idle
      if ($urandom_range(99) < 15) begin
        was_active = ellipse_active;
        step_word();
        if (was_active) sent++;
      end
    end
    wait_quiet();
  endtask

  // receiver holds off long enough for the block to back up and stall its input
  task automatic test_backpressure();
    set_idling(0, 0);
    @(negedge clk);
    hold_length = 300;
    @(posedge clk);
    start_word(RW'($urandom), RW'($urandom), RW'(14), RW'(10));
    while (ellipse_active) step_word();
    wait_quiet();
  endtask

  initial begin
    // reset asserted from time zero, once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_extremes();
    test_random_ellipses(225, 0, 0);
    test_random_ellipses(225, 74, 0);
    test_random_ellipses(225, 0, 74);
    test_random_ellipses(225, 32, 32);
    test_backpressure();

    if (pending_point_sets.size() != 0)
      report_mismatch($sformatf("%0d point sets never arrived", pending_point_sets.size()));
    if (mismatches == 0) begin
      $display("midpoint_ellipse_rasterizer_unit_test passed");
    end else begin
      $display("midpoint_ellipse_rasterizer_unit_test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: sim.f
rtl/midell_pkg.sv
rtl/midell_mul.sv
rtl/midell_ctrl.sv
rtl/midpoint_ellipse_rasterizer_unit.sv
tb/midpoint_ellipse_rasterizer_unit_test.sv
